>>> rtl/core/srp_pkg.sv
`timescale 1ns / 1ps
// Package with the status codes, the command codes, the region type and the shelf type of the shelf packer.
package srp_pkg;

    localparam logic [2:0] ST_PLACED    = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_BAD_KEY   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd4;
    localparam logic [2:0] ST_NO_ROOM   = 3'd5;
    localparam logic [2:0] ST_NOT_FOUND = 3'd6;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam int REGION_W = 53;

    typedef struct packed {
        logic [12:0] ye;
        logic [12:0] xe;
        logic [11:0] ys;
        logic [11:0] xs;
        logic [2:0]  page;
    } region_t;

    typedef struct packed {
        logic [12:0] cx;
        logic [12:0] ty;
        logic [12:0] tall;
    } shelf_t;

endpackage

>>> rtl/core/srp_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
module srp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/shelf_rect_packer.sv
`timescale 1ns / 1ps
// Top level of the multi-page shelf rectangle packer.
//
// Usage: one word enters on the s_axis group: tdata holds texture_id, width
// and height, tuser holds command. One result word leaves on the m_axis group
// per input word. The user must write page_size_log2 through cfg_we and
// cfg_wdata only while the block is idle; the block does not enforce this.
// Each item with a nonzero key first scans the key table, one entry per cycle
// through the key memory read port. A hit reads the stored region; otherwise the
// item goes to the checks and, for an add that passes them, to the page cursor
// scan through the shelf memory (a read state and an evaluate state per page).
// Last the output register is loaded.
// The block works on one item at a time; s_axis_tready is high only when no
// item is in progress and the result register is free.
// Reset clears the page cursors by a sweep over all NUM_PAGES entries, during which
// no item is accepted. It also sets one open page and an empty key table.
// When the receiver stalls, the result holds in the output register and the
// block accepts no further item until it is taken.
module shelf_rect_packer #(
    parameter int NUM_PAGES       = 8,
    parameter int NUM_ENTRIES     = 512,
    parameter int PAD_TEXELS      = 1,
    parameter int MAX_SPRITE_EDGE = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // texture_id [31:0], width [43:32], height [55:44]
    input  logic [55:0] s_axis_tdata,
    // command [0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // page_index [2:0], x_start [14:3], y_start [26:15], x_end [39:27], y_end [52:40]
    output logic [55:0] m_axis_tdata,
    // status [2:0]
    output logic [2:0]  m_axis_tuser
);

    localparam int EW = $clog2(NUM_ENTRIES);
    localparam int CW = $clog2(NUM_ENTRIES + 1);
    localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int OW = $clog2(NUM_PAGES + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_KEY, S_KEYWAIT, S_REG, S_CHECK, S_PREAD, S_PEVAL,
        S_OUT
    } state_t;

    state_t state_reg;
    logic [3:0]  psl_reg;
    logic [CW-1:0] count_reg;
    logic [OW-1:0] open_reg;
    logic [CW-1:0] idx_reg;
    logic [EW-1:0] hit_reg;
    logic [OW-1:0] page_reg;
    logic        cmd_reg;
    logic [31:0] key_reg;
    logic [11:0] w_reg, h_reg;
    logic [2:0]  st_reg;
    srp_pkg::region_t res_reg;
    logic        kv_reg;
    logic [EW-1:0] kaddr_reg;

    logic [31:0] key_rd;
    logic [srp_pkg::REGION_W-1:0] reg_rd;
    srp_pkg::shelf_t shelf_rd;
    logic        kwe, swe;
    logic [EW-1:0] kraddr, rraddr;
    logic [PW-1:0] saddr_w, saddr_r;
    srp_pkg::shelf_t swdata;
    srp_pkg::region_t new_region;

    logic [12:0] edge_len;
    logic [13:0] pw, ph, newy;
    logic        fit_a, fit_b, fresh;
    srp_pkg::shelf_t cur;

    always_comb
    begin
        case (psl_reg)
            4'd9:    edge_len = 13'd512;
            4'd10:   edge_len = 13'd1024;
            4'd11:   edge_len = 13'd2048;
            4'd12, 4'd13, 4'd14, 4'd15: edge_len = 13'd4096;
            default: edge_len = 13'd256;
        endcase
    end

    assign fresh = (page_reg == open_reg);
    assign cur   = fresh ? '0 : shelf_rd;
    assign pw    = {2'b00, w_reg} + 14'(PAD_TEXELS);
    assign ph    = {2'b00, h_reg} + 14'(PAD_TEXELS);
    assign newy  = {1'b0, cur.ty} + {1'b0, cur.tall};
    assign fit_a = ({1'b0, cur.cx} + pw <= {1'b0, edge_len})
                && ({1'b0, cur.ty} + ph <= {1'b0, edge_len});
    assign fit_b = (newy + ph <= {1'b0, edge_len}) && (pw <= {1'b0, edge_len});

    always_comb
    begin
        swdata = cur;
        new_region = '0;
        new_region.page = 3'(page_reg);
        if (fit_a)
        begin
            swdata.cx = 13'({1'b0, cur.cx} + pw);
            if (ph > {1'b0, cur.tall})
            begin
                swdata.tall = ph[12:0];
            end
            new_region.xs = cur.cx[11:0];
            new_region.ys = cur.ty[11:0];
        end
        else
        begin
            swdata.cx = pw[12:0];
            swdata.ty = newy[12:0];
            swdata.tall = ph[12:0];
            new_region.xs = '0;
            new_region.ys = newy[11:0];
        end
        new_region.xe = {1'b0, new_region.xs} + {1'b0, w_reg};
        new_region.ye = {1'b0, new_region.ys} + {1'b0, h_reg};
    end

    assign kraddr  = idx_reg[EW-1:0];
    assign rraddr  = hit_reg;
    assign saddr_r = page_reg[PW-1:0];
    assign kwe     = (state_reg == S_PEVAL) && (fit_a || fit_b);
    assign swe     = (state_reg == S_CLEAR)
                  || ((state_reg == S_PEVAL) && (fit_a || fit_b));
    assign saddr_w = page_reg[PW-1:0];

    srp_ram #(.WIDTH(32), .DEPTH(NUM_ENTRIES)) u_keys (
        .clk(clk), .we(kwe), .waddr(count_reg[EW-1:0]), .wdata(key_reg),
        .raddr(kraddr), .rdata(key_rd)
    );

    srp_ram #(.WIDTH(srp_pkg::REGION_W), .DEPTH(NUM_ENTRIES)) u_regions (
        .clk(clk), .we(kwe), .waddr(count_reg[EW-1:0]), .wdata(new_region),
        .raddr(rraddr), .rdata(reg_rd)
    );

    srp_ram #(.WIDTH($bits(srp_pkg::shelf_t)), .DEPTH(1 << PW)) u_shelves (
        .clk(clk), .we(swe), .waddr(saddr_w),
        .wdata((state_reg == S_CLEAR) ? '0 : swdata),
        .raddr(saddr_r), .rdata(shelf_rd)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && !m_axis_tvalid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            psl_reg       <= 4'd8;
            count_reg     <= '0;
            open_reg      <= OW'(1);
            page_reg      <= '0;
            m_axis_tvalid <= 1'b0;
            kv_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                psl_reg <= cfg_wdata;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                m_axis_tvalid <= 1'b0;
            end
            kv_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    if (page_reg == OW'(NUM_PAGES - 1))
                    begin
                        page_reg  <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        page_reg <= page_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        key_reg <= s_axis_tdata[31:0];
                        w_reg   <= s_axis_tdata[43:32];
                        h_reg   <= s_axis_tdata[55:44];
                        cmd_reg <= s_axis_tuser;
                        idx_reg <= '0;
                        res_reg <= '0;
                        if (s_axis_tdata[31:0] == 32'd0)
                        begin
                            st_reg    <= srp_pkg::ST_BAD_KEY;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_KEY;
                        end
                    end
                end
                S_KEY:
                begin
                    if (kv_reg && key_rd == key_reg)
                    begin
                        hit_reg   <= kaddr_reg;
                        state_reg <= S_KEYWAIT;
                    end
                    else if (idx_reg >= count_reg)
                    begin
                        if (!kv_reg)
                        begin
                            state_reg <= S_CHECK;
                        end
                    end
                    else
                    begin
                        kv_reg    <= 1'b1;
                        kaddr_reg <= idx_reg[EW-1:0];
                        idx_reg   <= idx_reg + 1'b1;
                    end
                end
                S_KEYWAIT:
                begin
                    state_reg <= S_REG;
                end
                S_REG:
                begin
                    res_reg   <= reg_rd;
                    st_reg    <= srp_pkg::ST_FOUND;
                    state_reg <= S_OUT;
                end
                S_CHECK:
                begin
                    page_reg <= '0;
                    if (cmd_reg == srp_pkg::CMD_LOOKUP)
                    begin
                        st_reg    <= srp_pkg::ST_NOT_FOUND;
                        state_reg <= S_OUT;
                    end
                    else if (count_reg >= CW'(NUM_ENTRIES))
                    begin
                        st_reg    <= srp_pkg::ST_FULL;
                        state_reg <= S_OUT;
                    end
                    else if (w_reg == 12'd0 || h_reg == 12'd0
                          || {1'b0, w_reg} > 13'(MAX_SPRITE_EDGE)
                          || {1'b0, h_reg} > 13'(MAX_SPRITE_EDGE)
                          || {1'b0, w_reg} > edge_len || {1'b0, h_reg} > edge_len)
                    begin
                        st_reg    <= srp_pkg::ST_BAD_SIZE;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_PREAD;
                    end
                end
                S_PREAD:
                begin
                    state_reg <= S_PEVAL;
                end
                S_PEVAL:
                begin
                    if (fit_a || fit_b)
                    begin
                        if (fresh)
                        begin
                            open_reg <= open_reg + 1'b1;
                        end
                        count_reg <= count_reg + 1'b1;
                        res_reg   <= new_region;
                        st_reg    <= srp_pkg::ST_PLACED;
                        state_reg <= S_OUT;
                    end
                    else if (fresh || (page_reg + 1'b1 == open_reg
                                      && open_reg >= OW'(NUM_PAGES)))
                    begin
                        if (fresh)
                        begin
                            open_reg <= open_reg + 1'b1;
                        end
                        st_reg    <= srp_pkg::ST_NO_ROOM;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        page_reg  <= page_reg + 1'b1;
                        state_reg <= S_PREAD;
                    end
                end
                S_OUT:
                begin
                    if (!m_axis_tvalid)
                    begin
                        m_axis_tvalid <= 1'b1;
                        m_axis_tuser  <= st_reg;
                        m_axis_tdata  <= {3'b000, res_reg};
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(NUM_ENTRIES))
        else $error("placed count exceeds table depth");
    a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg <= OW'(NUM_PAGES) && open_reg != '0)
        else $error("open page count out of range");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("input accepted while busy");
    a_write_placed: assert property (@(posedge clk) disable iff (!rst_n)
        kwe |=> (st_reg == srp_pkg::ST_PLACED && state_reg == S_OUT))
        else $error("table write without placement");
`endif

endmodule
